// ----- src/okl_pkg.sv -----
package okl_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_REMOVE = 3'd2,
    OP_INCR   = 3'd3,
    OP_DUMP   = 3'd4
  } okl_op_t;

  typedef enum logic [2:0] {
    STS_DONE      = 3'd0,
    STS_FULL      = 3'd1,
    STS_NOT_FOUND = 3'd2,
    STS_ENTRY     = 3'd3,
    STS_EMPTY     = 3'd4
  } okl_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DUMP
  } okl_state_t;

  // the action that every cell applies
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_INSERT,
    ACT_APPEND,
    ACT_REMOVE,
    ACT_INCR,
    ACT_ROTATE
  } okl_act_t;

  localparam int KEY_W     = 64;
  localparam int PAYLOAD_W = 64;
  localparam int COUNT_W   = 32;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   count;
  } okl_entry_t;

  typedef struct packed {
    logic     sample;
    okl_act_t act;
  } okl_ctrl_t;

endpackage

// ----- src/okl_cell.sv -----
module okl_cell (
  input  logic                         clk,
  input  okl_pkg::okl_ctrl_t           ctrl,
  input  logic                         occupied,
  input  logic                         is_tail,
  input  logic                         is_last,
  input  logic [okl_pkg::KEY_W-1:0]    cmp_key,
  input  okl_pkg::okl_entry_t          new_ent,
  input  okl_pkg::okl_entry_t          left_ent,
  input  okl_pkg::okl_entry_t          right_ent,
  input  okl_pkg::okl_entry_t          wrap_ent,
  input  logic                         hit_in,
  output logic                         hit_out,
  output okl_pkg::okl_entry_t          ent
);

  okl_pkg::okl_entry_t ent_r;
  okl_pkg::okl_entry_t ent_nxt;
  logic                match_r;

  // first-match chain: a hit anywhere upstream or here
  assign hit_out = hit_in | match_r;
  assign ent     = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    unique case (ctrl.act)
      okl_pkg::ACT_INSERT: ent_nxt = left_ent;
      okl_pkg::ACT_APPEND: begin
        if (is_tail) ent_nxt = new_ent;
      end
      okl_pkg::ACT_REMOVE: begin
        if (hit_out) ent_nxt = right_ent;
      end
      okl_pkg::ACT_INCR: begin
        if (match_r && !hit_in) ent_nxt.count = ent_r.count + okl_pkg::COUNT_W'(1);
      end
      okl_pkg::ACT_ROTATE: ent_nxt = is_last ? wrap_ent : right_ent;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (ctrl.sample) match_r <= occupied && (ent_r.key == cmp_key);
  end

endmodule

// ----- src/ordered_keyed_list_table.sv -----
// Ordered keyed list of up to DEPTH entries (key, payload, use counter) held
// in a row of cells. Insert, append, remove and increment each pass through
// the accepting cycle, in which every cell compares its key with the
// incoming one, and an apply cycle in which all cells shift or update at once
// and the single result is registered. A dump has the accepting cycle, a
// set-up cycle, then the row rotates by one place per cycle while the output
// is free and cell 0 feeds the output register, so after the last entry the
// list is back in its original order; an empty dump gives one result.
// The apply and rotate steps wait while the output register still holds an
// untaken result. A new transaction is taken only once the previous one has
// been fully applied.
module ordered_keyed_list_table #(
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     in_operation,
  input  logic [okl_pkg::KEY_W-1:0]      in_key,
  input  logic [okl_pkg::PAYLOAD_W-1:0]  in_payload,
  input  logic [okl_pkg::COUNT_W-1:0]    in_initial_count,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_status,
  output logic [okl_pkg::KEY_W-1:0]      out_entry_key,
  output logic [okl_pkg::PAYLOAD_W-1:0]  out_entry_payload,
  output logic [okl_pkg::COUNT_W-1:0]    out_entry_count,
  output logic                           out_last_of_run
);

  localparam int FW = $clog2(DEPTH + 1);

  // control state
  okl_pkg::okl_state_t state_r, state_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [FW-1:0]       dump_idx_r, dump_idx_nxt;
  logic                out_valid_r, out_valid_nxt;

  // latched transaction
  logic [2:0]          op_r;
  okl_pkg::okl_entry_t new_r;

  // result register
  logic [2:0]          out_status_r, out_status_nxt;
  okl_pkg::okl_entry_t out_ent_r, out_ent_nxt;
  logic                out_last_r, out_last_nxt;

  okl_pkg::okl_ctrl_t  ctrl;
  okl_pkg::okl_entry_t ents [DEPTH];
  logic [DEPTH:0]      hit;

  logic in_acc;
  logic out_free;
  logic full;
  logic found;

  assign in_ready = (state_r == okl_pkg::ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign full     = (fill_r == FW'(DEPTH));
  assign hit[0]   = 1'b0;
  assign found    = hit[DEPTH];

  // the row of cells; cell 0 is the head of the list
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    okl_pkg::okl_entry_t left_ent;
    okl_pkg::okl_entry_t right_ent;

    if (i == 0) begin : g_head
      assign left_ent = new_r;
    end else begin : g_mid
      assign left_ent = ents[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_ent = ents[i];
    end else begin : g_inner
      assign right_ent = ents[i+1];
    end

    okl_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occupied  (FW'(i) < fill_r),
      .is_tail   (fill_r == FW'(i)),
      .is_last   (fill_r == FW'(i + 1)),
      .cmp_key   (in_key),
      .new_ent   (new_r),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .wrap_ent  (ents[0]),
      .hit_in    (hit[i]),
      .hit_out   (hit[i+1]),
      .ent       (ents[i])
    );
  end

  // sequencer: next state, cell commands and result
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    dump_idx_nxt   = dump_idx_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_last_nxt   = out_last_r;
    ctrl.sample    = in_acc;
    ctrl.act       = okl_pkg::ACT_NONE;

    unique case (state_r)
      okl_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = okl_pkg::ST_APPLY;
      end

      okl_pkg::ST_APPLY: begin
        if (out_free) begin
          out_ent_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = okl_pkg::STS_DONE;
          out_valid_nxt  = 1'b1;
          state_nxt      = okl_pkg::ST_IDLE;
          case (op_r) inside
            okl_pkg::OP_INSERT, okl_pkg::OP_APPEND: begin
              if (full) begin
                out_status_nxt = okl_pkg::STS_FULL;
              end else begin
                ctrl.act = (op_r == okl_pkg::OP_INSERT) ? okl_pkg::ACT_INSERT
                                                        : okl_pkg::ACT_APPEND;
                fill_nxt = fill_r + FW'(1);
              end
            end
            okl_pkg::OP_REMOVE: begin
              if (!found) begin
                out_status_nxt = okl_pkg::STS_NOT_FOUND;
              end else begin
                ctrl.act = okl_pkg::ACT_REMOVE;
                fill_nxt = fill_r - FW'(1);
              end
            end
            okl_pkg::OP_INCR: begin
              if (!found) out_status_nxt = okl_pkg::STS_NOT_FOUND;
              else        ctrl.act       = okl_pkg::ACT_INCR;
            end
            okl_pkg::OP_DUMP: begin
              if (fill_r == '0) begin
                out_status_nxt = okl_pkg::STS_EMPTY;
              end else begin
                // no result yet, the rotation starts in ST_DUMP
                out_valid_nxt = out_valid_r && !out_ready;
                dump_idx_nxt  = '0;
                state_nxt     = okl_pkg::ST_DUMP;
              end
            end
            default: ;  // unused codes answer done and leave the list alone
          endcase
        end
      end

      okl_pkg::ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = okl_pkg::STS_ENTRY;
          out_ent_nxt    = ents[0];
          out_last_nxt   = (dump_idx_r == fill_r - FW'(1));
          ctrl.act       = okl_pkg::ACT_ROTATE;
          dump_idx_nxt   = dump_idx_r + FW'(1);
          if (out_last_nxt) state_nxt = okl_pkg::ST_IDLE;
        end
      end

      default: state_nxt = okl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= okl_pkg::ST_IDLE;
      fill_r      <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      dump_idx_r  <= dump_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r          <= in_operation;
      new_r.key     <= in_key;
      new_r.payload <= in_payload;
      new_r.count   <= in_initial_count;
    end
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_key     = out_ent_r.key;
  assign out_entry_payload = out_ent_r.payload;
  assign out_entry_count   = out_ent_r.count;
  assign out_last_of_run   = out_last_r;

  // fill level never passes the capacity of the row
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(DEPTH))
    else $error("fill level beyond depth");

  // a dump rotation only runs over a non-empty list
  a_dump_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == okl_pkg::ST_DUMP) |-> (fill_r != '0))
    else $error("dump running on empty list");

  // a successful insert or append grows the list by one
  a_grow : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == okl_pkg::ST_APPLY && out_free && !full &&
     (op_r == okl_pkg::OP_INSERT || op_r == okl_pkg::OP_APPEND))
    |=> (fill_r == $past(fill_r) + FW'(1)))
    else $error("fill level not advanced on insert");

  // no new transaction is taken while a dump is still draining
  a_no_accept_in_dump : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == okl_pkg::ST_DUMP && !(out_free && out_last_nxt)) |=> !in_ready)
    else $error("input taken during dump");

endmodule

// ----- verif/okl_list_checker.sv -----
`timescale 1ns / 100ps

module okl_list_checker #(
  parameter int DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [2:0]                      in_operation,
  input  logic [okl_pkg::KEY_W-1:0]       in_key,
  input  logic [okl_pkg::PAYLOAD_W-1:0]   in_payload,
  input  logic [okl_pkg::COUNT_W-1:0]     in_initial_count,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [2:0]                      out_status,
  input  logic [okl_pkg::KEY_W-1:0]       out_entry_key,
  input  logic [okl_pkg::PAYLOAD_W-1:0]   out_entry_payload,
  input  logic [okl_pkg::COUNT_W-1:0]     out_entry_count,
  input  logic                            out_last_of_run,
  output int                              fail_count,
  output int                              pending,
  output int                              results_checked,
  output int                              peak_fill,
  output int                              full_refusals,
  output int                              dumps_seen
);

  typedef struct packed {
    okl_pkg::okl_status_t          status;
    logic [okl_pkg::KEY_W-1:0]     key;
    logic [okl_pkg::PAYLOAD_W-1:0] payload;
    logic [okl_pkg::COUNT_W-1:0]   count;
    logic                          last;
  } okl_result_t;

  okl_pkg::okl_entry_t list_entries [DEPTH];
  int                  list_fill    = 0;
  okl_result_t         expected_results [$];
  int                  errors       = 0;
  int                  results_seen = 0;
  int                  fill_peak    = 0;
  int                  refusals     = 0;
  int                  dumps        = 0;

  task automatic push_result(input okl_pkg::okl_status_t st,
                             input logic [okl_pkg::KEY_W-1:0] k,
                             input logic [okl_pkg::PAYLOAD_W-1:0] p,
                             input logic [okl_pkg::COUNT_W-1:0] c,
                             input logic last);
    okl_result_t r;
    r.status  = st;
    r.key     = k;
    r.payload = p;
    r.count   = c;
    r.last    = last;
    expected_results.push_back(r);
  endtask

  task automatic apply_list_op(input logic [2:0] op, input logic [okl_pkg::KEY_W-1:0] key,
                               input logic [okl_pkg::PAYLOAD_W-1:0] payload,
                               input logic [okl_pkg::COUNT_W-1:0] count);
    int                  hit;
    okl_pkg::okl_entry_t fresh;
    hit = -1;
    for (int i = 0; i < list_fill; i++) begin
      if (hit < 0 && list_entries[i].key == key) hit = i;
    end
    fresh.key     = key;
    fresh.payload = payload;
    fresh.count   = count;
    case (op) inside
      okl_pkg::OP_INSERT, okl_pkg::OP_APPEND: begin
        if (list_fill >= DEPTH) begin
          refusals++;
          push_result(okl_pkg::STS_FULL, '0, '0, '0, 1'b1);
        end else begin
          if (op == okl_pkg::OP_INSERT) begin
            for (int i = list_fill; i > 0; i--) list_entries[i] = list_entries[i-1];
            list_entries[0] = fresh;
          end else begin
            list_entries[list_fill] = fresh;
          end
          list_fill++;
          if (list_fill > fill_peak) fill_peak = list_fill;
          push_result(okl_pkg::STS_DONE, '0, '0, '0, 1'b1);
        end
      end
      okl_pkg::OP_REMOVE: begin
        if (hit < 0) begin
          push_result(okl_pkg::STS_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          for (int i = hit; i + 1 < list_fill; i++) list_entries[i] = list_entries[i+1];
          list_fill--;
          push_result(okl_pkg::STS_DONE, '0, '0, '0, 1'b1);
        end
      end
      okl_pkg::OP_INCR: begin
        if (hit < 0) begin
          push_result(okl_pkg::STS_NOT_FOUND, '0, '0, '0, 1'b1);
        end else begin
          list_entries[hit].count = list_entries[hit].count + okl_pkg::COUNT_W'(1);
          push_result(okl_pkg::STS_DONE, '0, '0, '0, 1'b1);
        end
      end
      okl_pkg::OP_DUMP: begin
        dumps++;
        if (list_fill == 0) begin
          push_result(okl_pkg::STS_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < list_fill; i++) begin
            push_result(okl_pkg::STS_ENTRY, list_entries[i].key, list_entries[i].payload,
                        list_entries[i].count, i == list_fill - 1);
          end
        end
      end
      default: push_result(okl_pkg::STS_DONE, '0, '0, '0, 1'b1);
    endcase
  endtask

  task automatic report(input string field, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    okl_result_t oldest;
    if (!rst_n) begin
      list_fill = 0;
      expected_results.delete();
    end else begin
      // results first, so a result cannot be matched to a transaction taken at this edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got status %0d key %0h",
                   $time, out_status, out_entry_key);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          report("status", 64'(oldest.status), 64'(out_status));
          report("entry_key", oldest.key, out_entry_key);
          report("entry_payload", oldest.payload, out_entry_payload);
          report("entry_count", 64'(oldest.count), 64'(out_entry_count));
          report("last_of_run", 64'(oldest.last), 64'(out_last_of_run));
          results_seen++;
        end
      end
      if (in_valid && in_ready) begin
        apply_list_op(in_operation, in_key, in_payload, in_initial_count);
      end
    end
    pending         <= expected_results.size();
    fail_count      <= errors;
    results_checked <= results_seen;
    peak_fill       <= fill_peak;
    full_refusals   <= refusals;
    dumps_seen      <= dumps;
  end

endmodule

// ----- verif/ordered_keyed_list_table_test.sv -----
`timescale 1ns / 100ps

module ordered_keyed_list_table_test;

  localparam int DEPTH        = 32;
  localparam int RANDOM_ITEMS = 312;
  localparam int KEY_POOL     = 12;
  // worst case is roughly 330 dumps of 32 results behind long stalls
  localparam int CYCLE_LIMIT  = 400000;
  // a full dump drains one entry per cycle while out_ready is high, after a set-up cycle
  localparam int DRAIN_CYCLES = DEPTH + 8;

  // operation mixes for the random segments
  localparam int MIX_FILL     = 0;
  localparam int MIX_BALANCED = 1;
  localparam int MIX_DRAIN    = 2;

  // receiver behaviour
  localparam int READY_ALWAYS   = 0;
  localparam int READY_COIN     = 1;
  localparam int READY_PERIODIC = 2;
  localparam int READY_SPARSE   = 3;

  logic                           clk;
  logic                           rst_n             = 1'b0;
  logic                           in_valid          = 1'b0;
  logic                           in_ready;
  logic [2:0]                     in_operation      = '0;
  logic [okl_pkg::KEY_W-1:0]      in_key            = '0;
  logic [okl_pkg::PAYLOAD_W-1:0]  in_payload        = '0;
  logic [okl_pkg::COUNT_W-1:0]    in_initial_count  = '0;
  logic                           out_valid;
  logic                           out_ready         = 1'b0;
  logic [2:0]                     out_status;
  logic [okl_pkg::KEY_W-1:0]      out_entry_key;
  logic [okl_pkg::PAYLOAD_W-1:0]  out_entry_payload;
  logic [okl_pkg::COUNT_W-1:0]    out_entry_count;
  logic                           out_last_of_run;

  int fail_count;
  int pending;
  int results_checked;
  int peak_fill;
  int full_refusals;
  int dumps_seen;

  int cycle_count  = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int ready_mode   = READY_ALWAYS;
  int ready_left   = 0;

  logic [okl_pkg::KEY_W-1:0] key_pool [KEY_POOL];

  ordered_keyed_list_table #(
    .DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .in_initial_count (in_initial_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_key    (out_entry_key),
    .out_entry_payload(out_entry_payload),
    .out_entry_count  (out_entry_count),
    .out_last_of_run  (out_last_of_run)
  );

  // predicts every result and compares it as it is taken
  okl_list_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .in_payload       (in_payload),
    .in_initial_count (in_initial_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_entry_key    (out_entry_key),
    .out_entry_payload(out_entry_payload),
    .out_entry_count  (out_entry_count),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_checked  (results_checked),
    .peak_fill        (peak_fill),
    .full_refusals    (full_refusals),
    .dumps_seen       (dumps_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("** ordered_keyed_list_table: FAILED **");
      $finish;
    end
  end

  // receiver stalls: a mode is held for a random stretch, then another is drawn
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(READY_ALWAYS, READY_SPARSE);
      ready_left <= $urandom_range(20, 120);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_COIN:     out_ready <= $urandom_range(0, 1) == 1;
      READY_PERIODIC: out_ready <= (ready_left % 4) != 0;
      default:        out_ready <= $urandom_range(0, 7) == 0;
    endcase
  end

  // one transaction, preceded on most calls by an idle gap when a burst runs out;
  // valid is left high on return so the next call can follow back to back
  task automatic send_item(input logic [2:0] op, input logic [okl_pkg::KEY_W-1:0] key,
                           input logic [okl_pkg::PAYLOAD_W-1:0] payload,
                           input logic [okl_pkg::COUNT_W-1:0] count);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_key           <= key;
    in_payload       <= payload;
    in_initial_count <= count;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // mostly keys from a small pool so that remove and increment find matches
  function automatic logic [okl_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL - 1)];
    return {$urandom, $urandom};
  endfunction

  // counters near the top now and then, so increments wrap
  function automatic logic [okl_pkg::COUNT_W-1:0] pick_count();
    if ($urandom_range(0, 9) == 0) return '1 - okl_pkg::COUNT_W'($urandom_range(0, 2));
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_op(input int mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 45) return okl_pkg::OP_INSERT;
        if (roll < 85) return okl_pkg::OP_APPEND;
        if (roll < 90) return okl_pkg::OP_INCR;
        if (roll < 93) return okl_pkg::OP_REMOVE;
        if (roll < 97) return okl_pkg::OP_DUMP;
      end
      MIX_BALANCED: begin
        if (roll < 25) return okl_pkg::OP_INSERT;
        if (roll < 45) return okl_pkg::OP_APPEND;
        if (roll < 65) return okl_pkg::OP_REMOVE;
        if (roll < 82) return okl_pkg::OP_INCR;
        if (roll < 95) return okl_pkg::OP_DUMP;
      end
      default: begin
        if (roll < 8) return okl_pkg::OP_INSERT;
        if (roll < 15) return okl_pkg::OP_APPEND;
        if (roll < 65) return okl_pkg::OP_REMOVE;
        if (roll < 82) return okl_pkg::OP_INCR;
        if (roll < 95) return okl_pkg::OP_DUMP;
      end
    endcase
    // codes beyond the defined set
    return 3'($urandom_range(int'(okl_pkg::OP_DUMP) + 1, 7));
  endfunction

  initial begin : stimulus
    int mix_order [4];
    int segment;
    int seg_len;
    int random_sent;

    mix_order[0] = MIX_FILL;
    mix_order[1] = MIX_BALANCED;
    mix_order[2] = MIX_DRAIN;
    mix_order[3] = MIX_BALANCED;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, missing keys, field extremes, duplicate keys,
    // counter wrap, undefined codes and emptying the list again
    send_item(okl_pkg::OP_DUMP,   '0, '0, '0);
    send_item(okl_pkg::OP_REMOVE, '0, '0, '0);
    send_item(okl_pkg::OP_INCR,   '1, '1, '1);
    send_item(okl_pkg::OP_INSERT, '0, '1, '1);
    send_item(okl_pkg::OP_APPEND, '1, '0, '0);
    send_item(okl_pkg::OP_INCR,   '0, '0, '0);
    send_item(okl_pkg::OP_INSERT, '1, 64'ha5a5_5a5a_0f0f_f0f0, 32'd5);
    send_item(okl_pkg::OP_INCR,   '1, '0, '0);
    send_item(okl_pkg::OP_DUMP,   '0, '0, '0);
    send_item(okl_pkg::OP_REMOVE, '1, '0, '0);
    send_item(okl_pkg::OP_DUMP,   '1, '1, '1);
    send_item(3'(int'(okl_pkg::OP_DUMP) + 1), '1, '1, '1);
    send_item(3'(int'(okl_pkg::OP_DUMP) + 2), '0, '0, '0);
    send_item(3'(int'(okl_pkg::OP_DUMP) + 3), {$urandom, $urandom}, {$urandom, $urandom},
              $urandom);
    send_item(okl_pkg::OP_REMOVE, '0, '0, '0);
    send_item(okl_pkg::OP_REMOVE, '1, '0, '0);
    send_item(okl_pkg::OP_REMOVE, '1, '0, '0);
    send_item(okl_pkg::OP_DUMP,   '0, '0, '0);

    // random segments: fill to the top first, then balanced and draining mixes
    random_sent = 0;
    segment = 0;
    while (random_sent < RANDOM_ITEMS) begin
      seg_len = (segment == 0) ? 50 : $urandom_range(30, 50);
      for (int i = 0; i < seg_len && random_sent < RANDOM_ITEMS; i++) begin
        send_item(pick_op(mix_order[segment % 4]), pick_key(), {$urandom, $urandom},
                  pick_count());
        random_sent++;
      end
      segment++;
    end

    in_valid <= 1'b0;
    // the outstanding count is registered in the checker
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d transactions sent, %0d results checked, %0d dumps",
             items_sent, results_checked, dumps_seen);
    $display("summary: list filled to %0d of %0d entries, %0d inserts refused when full",
             peak_fill, DEPTH, full_refusals);
    if (fail_count == 0) begin
      $display("** ordered_keyed_list_table: PASSED **");
    end else begin
      $display("** ordered_keyed_list_table: FAILED **");
    end
    $finish;
  end

endmodule
